>>> rtl/subset_order_min_cost_assert.svh
// Assertion macros for the subset ordering block.
// Used by the top level; depends on nothing else.
`ifndef SUBSET_ORDER_MIN_COST_ASSERT_SVH
`define SUBSET_ORDER_MIN_COST_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define SOC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define SOC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/soc_pkg.sv
// Shared types and constants for the subset ordering block.
// No dependencies.
`timescale 1ns / 1ps

package soc_pkg;

    localparam int TotalW = 24;
    localparam logic [TotalW-1:0] TOTAL_MAX = 24'hFFFFFF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SOLVE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic              valid;
        logic [TotalW-1:0] total;
    } t_done;

endpackage

>>> rtl/soc_solver.sv
// Cost matrix memory, best-cost memory and the subset sweep sequencer.
// Depends on soc_pkg.
`timescale 1ns / 1ps

module soc_solver import soc_pkg::*; #(
    parameter int MAX_ITEMS = 14,
    parameter int NW = $clog2(MAX_ITEMS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [3:0]    i_wr_row,
    input  logic [3:0]    i_wr_col,
    input  logic [15:0]   i_wr_cost,
    input  logic          i_start,
    input  logic [NW-1:0] i_n,
    output logic          o_busy,
    output t_done         o_done
);

    localparam int IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CD = MAX_ITEMS * MAX_ITEMS;
    localparam int CW = (CD > 1) ? $clog2(CD) : 1;
    localparam int SD = 1 << MAX_ITEMS;

    // memories
    logic [15:0]       cost_mem [CD];
    logic [TotalW-1:0] best_mem [SD];
    logic [15:0]       r_cost_rd;
    logic [TotalW-1:0] r_best_rd;

    t_state r_state, n_state;
    logic [MAX_ITEMS-1:0] r_set, n_set;
    logic [IW-1:0]        r_i, n_i, r_j, n_j;

    logic                 issue, drain_empty, last_j, last_i, set_full;
    logic [MAX_ITEMS-1:0] full_mask, pred;
    logic [CW-1:0]        cost_raddr, cost_waddr;
    logic                 wr_ok;

    // stage one tags
    logic r_p_valid, r_p_jin, r_p_first, r_p_last, r_p_iin, r_p_firsti, r_p_lasti, r_p_bzero;
    logic [MAX_ITEMS-1:0] r_p_set;
    logic [TotalW-1:0] r_acc, acc_in, acc_new, addend;
    logic [TotalW:0]   acc_sum;

    // stage two
    logic r_t_valid, r_t_iin, r_t_firsti, r_t_lasti;
    logic [MAX_ITEMS-1:0] r_t_set;
    logic [TotalW-1:0] r_t_acc, r_t_base, tot, min_sel, n_min, r_min;
    logic [TotalW:0]   tot_sum;

    // decode the active set
    always_comb begin
        for (int k = 0; k < MAX_ITEMS; k++) begin
            full_mask[k] = (NW'(k) < i_n);
        end
    end

    assign last_j      = (NW'(r_j) == i_n - NW'(1));
    assign last_i      = (NW'(r_i) == i_n - NW'(1));
    assign set_full    = (r_set == full_mask);
    assign drain_empty = !r_p_valid && !r_t_valid;
    assign pred        = r_set & ~({{(MAX_ITEMS-1){1'b0}}, 1'b1} << r_i);
    assign cost_raddr  = CW'(r_i * MAX_ITEMS + r_j);
    assign cost_waddr  = CW'(i_wr_row * MAX_ITEMS + i_wr_col);
    assign wr_ok       = i_wr_en && (5'(i_wr_row) < 5'(MAX_ITEMS))
                         && (5'(i_wr_col) < 5'(MAX_ITEMS));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_start) n_state = ST_ISSUE;
            ST_ISSUE: if (last_i && last_j) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (drain_empty) n_state = set_full ? ST_IDLE : ST_ISSUE;
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // counters and strobes
    always_comb begin
        issue  = 1'b0;
        n_set  = r_set;
        n_i    = r_i;
        n_j    = r_j;
        o_busy = (r_state != ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                n_set = {{(MAX_ITEMS-1){1'b0}}, 1'b1};
                n_i   = '0;
                n_j   = '0;
            end
            ST_ISSUE: begin
                issue = 1'b1;
                if (last_j) begin
                    n_j = '0;
                    n_i = last_i ? '0 : r_i + IW'(1);
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (drain_empty && !set_full) n_set = r_set + MAX_ITEMS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_set <= n_set;
        r_i   <= n_i;
        r_j   <= n_j;
    end

    // cost matrix port
    always_ff @(posedge i_clk) begin
        if (wr_ok) cost_mem[cost_waddr] <= i_wr_cost;
        r_cost_rd <= cost_mem[cost_raddr];
    end

    // best-cost port: write the finished set, read the predecessor
    always_ff @(posedge i_clk) begin
        if (r_t_valid && r_t_lasti) best_mem[r_t_set] <= n_min;
        r_best_rd <= best_mem[pred];
    end

    // stage one: accumulate the row sum over members
    assign addend  = r_p_jin ? {8'd0, r_cost_rd} : '0;
    assign acc_in  = r_p_first ? '0 : r_acc;
    assign acc_sum = {1'b0, acc_in} + {1'b0, addend};
    assign acc_new = acc_sum[TotalW] ? TOTAL_MAX : acc_sum[TotalW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_t_valid <= 1'b0;
        end else begin
            r_p_valid <= issue;
            r_t_valid <= r_p_valid && r_p_last;
        end
        r_p_jin    <= r_set[r_j];
        r_p_first  <= (r_j == '0);
        r_p_last   <= last_j;
        r_p_iin    <= r_set[r_i];
        r_p_firsti <= (r_i == '0);
        r_p_lasti  <= last_i;
        r_p_bzero  <= (pred == '0);
        r_p_set    <= r_set;
        if (r_p_valid) r_acc <= acc_new;
        r_t_acc    <= acc_new;
        r_t_base   <= r_p_bzero ? '0 : r_best_rd;
        r_t_iin    <= r_p_iin;
        r_t_firsti <= r_p_firsti;
        r_t_lasti  <= r_p_lasti;
        r_t_set    <= r_p_set;
    end

    // stage two: add the predecessor cost and keep the minimum
    assign tot_sum = {1'b0, r_t_base} + {1'b0, r_t_acc};
    assign tot     = tot_sum[TotalW] ? TOTAL_MAX : tot_sum[TotalW-1:0];
    assign min_sel = r_t_firsti ? TOTAL_MAX : r_min;
    assign n_min   = (r_t_iin && (tot < min_sel)) ? tot : min_sel;

    always_ff @(posedge i_clk) begin
        if (r_t_valid) r_min <= n_min;
    end

    assign o_done.valid = r_t_valid && r_t_lasti && (r_t_set == full_mask);
    assign o_done.total = n_min;

endmodule

>>> rtl/subset_order_min_cost.sv
// Top level of the subset ordering block: request handshakes, item count
// register and result register. Depends on soc_pkg, soc_solver and the macros.
`timescale 1ns / 1ps
`include "subset_order_min_cost_assert.svh"

// Usage:
//   Input channel (i_in_valid / o_in_stall) carries requests. op = write
//   stores cost[row][col]; indices at or above MAX_ITEMS are dropped.
//   op = solve sweeps every nonempty subset in increasing order.
//   Config channel (i_cfg_valid / o_cfg_ready) sets item_count n, clamped
//   to 1..MAX_ITEMS; write it only while the block is idle.
//   Each subset of a solve makes n*n reads of the cost memory, one per
//   cycle, then waits for its best-cost entry to be written back before
//   the next subset reads it. No request is taken while a solve runs.
//   The result appears on o_out_valid / o_min_total and holds while
//   i_out_stall is high; writes are still taken meanwhile, but a new solve
//   is stalled until the pending result is taken.
//   Reset clears control state and sets item_count to 1; the cost memory
//   holds nothing defined until written.
module subset_order_min_cost import soc_pkg::*; #(
    parameter int MAX_ITEMS = 14
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_op,
    input  logic [3:0]  i_row,
    input  logic [3:0]  i_col,
    input  logic [15:0] i_cost,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [23:0] o_min_total
);

    localparam int NW = $clog2(MAX_ITEMS + 1);

    logic [3:0]        r_item_count;
    logic [NW-1:0]     n_eff;
    logic              busy, in_acc, out_acc, start;
    t_done             done;
    logic              r_out_valid;
    logic [TotalW-1:0] r_out_total;

    // clamp the item count
    always_comb begin
        if (r_item_count == 4'd0) n_eff = NW'(1);
        else if (5'(r_item_count) > 5'(MAX_ITEMS)) n_eff = NW'(MAX_ITEMS);
        else n_eff = NW'(r_item_count);
    end

    // handshakes
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = busy || ((i_op == OP_SOLVE) && r_out_valid);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign start       = in_acc && (i_op == OP_SOLVE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_item_count <= i_cfg_data;
        end
    end

    soc_solver #(.MAX_ITEMS(MAX_ITEMS), .NW(NW)) u_solver (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc && (i_op == OP_WRITE)),
        .i_wr_row  (i_row),
        .i_wr_col  (i_col),
        .i_wr_cost (i_cost),
        .i_start   (start),
        .i_n       (n_eff),
        .o_busy    (busy),
        .o_done    (done)
    );

    // hold the result until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done.valid) begin
            r_out_valid <= 1'b1;
        end else if (out_acc) begin
            r_out_valid <= 1'b0;
        end
        if (done.valid) r_out_total <= done.total;
    end

    assign o_out_valid = r_out_valid;
    assign o_min_total = r_out_total;

    `SOC_ASSERT_NOW(a_done_free, i_clk, i_rst_n, done.valid, !r_out_valid, "result overrun")
    `SOC_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start, busy, "solve did not start")
    `SOC_ASSERT_NEXT(a_out_clear, i_clk, i_rst_n, out_acc && !done.valid, !o_out_valid, "result repeated")

endmodule

>>> test/tb_subset_order_min_cost.sv
// Testbench for subset_order_min_cost: loads cost matrices, solves, and checks
// each minimum total against a built-in subset sweep. Depends on soc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_subset_order_min_cost;
    import soc_pkg::*;

    localparam int MaxItems = 14;
    localparam logic [23:0] SatTotal = 24'hFFFFFF;
    localparam int IdleLimit = 10000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_op;
    logic [3:0]  i_row;
    logic [3:0]  i_col;
    logic [15:0] i_cost;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [3:0]  i_cfg_data;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [23:0] o_min_total;

    // Predictor state: cost matrix and active item count.
    logic [15:0] cost_mem [MaxItems*MaxItems];
    logic [3:0]  count_reg;
    logic [23:0] sweep_best [1<<MaxItems];
    logic [23:0] pending_totals [$];

    int error_count;
    int sent_count;
    int solve_count;
    int idle_cycles = 0;
    int max_n_seen;

    subset_order_min_cost dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic [23:0] sat_sum(input logic [23:0] a, input logic [23:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? SatTotal : s[23:0];
    endfunction

    // Subset sweep: cheapest order to build the full set of active items.
    function automatic logic [23:0] min_order_total();
        int n;
        int full;
        logic [23:0] step;
        n = (count_reg == 0) ? 1 : (count_reg > MaxItems ? MaxItems : int'(count_reg));
        full = (1 << n) - 1;
        sweep_best[0] = '0;
        for (int s = 1; s <= full; s++) sweep_best[s] = SatTotal;
        for (int s = 0; s < full; s++) begin
            for (int i = 0; i < n; i++) begin
                if (s[i]) continue;
                step = {8'd0, cost_mem[i*MaxItems+i]};
                for (int j = 0; j < n; j++)
                    if (s[j]) step = sat_sum(step, {8'd0, cost_mem[i*MaxItems+j]});
                step = sat_sum(sweep_best[s], step);
                if (step < sweep_best[s | (1 << i)]) sweep_best[s | (1 << i)] = step;
            end
        end
        return sweep_best[full];
    endfunction

    // Send one request after a random gap; predict on acceptance.
    task automatic send_request(input logic op, input logic [3:0] row, input logic [3:0] col,
                                input logic [15:0] cost);
        int gap;
        gap = $urandom_range(11);
        if ($urandom_range(3) == 0) gap = 0;
        repeat (gap) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_op = op;
        i_row = row;
        i_col = col;
        i_cost = cost;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (op == OP_WRITE) begin
            if (row < MaxItems && col < MaxItems) begin
                cost_mem[row*MaxItems+col] = cost;
            end
        end else begin
            pending_totals.push_back(min_order_total());
            solve_count++;
        end
        sent_count++;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_op = 1'($urandom_range(1));
        i_row = 4'($urandom_range(15));
        i_col = 4'($urandom_range(15));
        i_cost = 16'($urandom_range(16'hFFFF));
    endtask

    // Wait for every expected total, then let an in-flight write settle.
    task automatic drain_results();
        while (pending_totals.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_count(input logic [3:0] value);
        drain_results();
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        count_reg = value;
        if (int'(value) > max_n_seen) max_n_seen = int'(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Fill the active matrix so that no solve reads an unwritten entry.
    task automatic load_matrix(input int n, input int style);
        logic [15:0] v;
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++) begin
                case (style)
                    0: v = 16'($urandom_range(16'hFFFF));
                    1: v = 16'hFFFF;
                    2: v = 16'h0000;
                    default: v = 16'($urandom_range(40));
                endcase
                send_request(OP_WRITE, r[3:0], c[3:0], v);
            end
    endtask

    task automatic solve_now();
        send_request(OP_SOLVE, 4'($urandom_range(15)), 4'($urandom_range(15)),
                     16'($urandom_range(16'hFFFF)));
    endtask

    // Directed: count one, both extremes of cost, ignored out-of-range writes.
    task automatic test_directed();
        write_count(4'd1);
        send_request(OP_WRITE, 4'd0, 4'd0, 16'hFFFF);
        solve_now();
        send_request(OP_WRITE, 4'd0, 4'd0, 16'h0000);
        solve_now();
        send_request(OP_WRITE, 4'd14, 4'd3, 16'h1234);
        send_request(OP_WRITE, 4'd2, 4'd15, 16'hAAAA);
        send_request(OP_WRITE, 4'd15, 4'd15, 16'h5555);
        send_request(OP_WRITE, 4'd13, 4'd13, 16'hFFFF);
        solve_now();
        write_count(4'd2);
        load_matrix(2, 1);
        solve_now();
        write_count(4'd3);
        load_matrix(3, 2);
        solve_now();
        solve_now();
    endtask

    // Clamping of item count: zero acts as one, above the limit acts as the limit.
    task automatic test_count_clamp();
        write_count(4'd0);
        solve_now();
        write_count(4'd15);
        load_matrix(MaxItems, 3);
        solve_now();
        write_count(4'd14);
        send_request(OP_WRITE, 4'd5, 4'd9, 16'hFFFF);
        solve_now();
    endtask

    // Random: small sizes mostly, reloaded matrices, random partial rewrites.
    task automatic test_random();
        int n;
        while (sent_count < 750) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 6);
            write_count(n[3:0]);
            load_matrix(n, ($urandom_range(5) == 0) ? 1 : $urandom_range(3) == 0 ? 3 : 0);
            repeat ($urandom_range(1, 3)) begin
                repeat ($urandom_range(4)) begin
                    if ($urandom_range(4) == 0)
                        send_request(OP_WRITE, 4'($urandom_range(15)),
                                     4'($urandom_range(15)),
                                     16'($urandom_range(16'hFFFF)));
                    else
                        send_request(OP_WRITE, 4'($urandom_range(n-1)),
                                     4'($urandom_range(n-1)),
                                     16'($urandom_range(16'hFFFF)));
                end
                solve_now();
            end
        end
    endtask

    // Result checker with random back-pressure.
    initial begin
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall = 1'b1;
                hold--;
            end else begin
                i_out_stall = 1'b0;
                hold = ($urandom_range(2) == 0) ? 0 : $urandom_range(11);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_totals.size() == 0) begin
                report_mismatch("unexpected result", o_min_total, '0);
            end else begin
                if (o_min_total !== pending_totals[0])
                    report_mismatch("min_total", o_min_total, pending_totals[0]);
                void'(pending_totals.pop_front());
            end
        end
    end

    // Watchdog on cycles with no accepted request or result.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog expired");
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        sent_count = 0;
        solve_count = 0;
        max_n_seen = 0;
        count_reg = 4'd1;
        for (int k = 0; k < MaxItems*MaxItems; k++) begin
            cost_mem[k] = '0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_WRITE;
        i_row = '0;
        i_col = '0;
        i_cost = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_count_clamp();
        test_random();
        drain_results();

        $display("covered %0d requests, %0d solves, item counts up to %0d",
                 sent_count, solve_count, max_n_seen);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/soc_pkg.sv
rtl/soc_solver.sv
rtl/subset_order_min_cost.sv
test/tb_subset_order_min_cost.sv
